>>> rtl/mbrd_pkg.sv
// ---------------------------------------------------------------------------
// mbrd_pkg
// types, codes and small tables shared by the meter bus record deframer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbrd_pkg;

  // result status codes
  localparam logic [3:0] ST_RECORD     = 4'd0;
  localparam logic [3:0] ST_MANUF      = 4'd1;
  localparam logic [3:0] ST_MORE       = 4'd2;
  localparam logic [3:0] ST_END        = 4'd3;
  localparam logic [3:0] ST_TRUNC_DIFE = 4'd4;
  localparam logic [3:0] ST_MANY_DIFE  = 4'd5;
  localparam logic [3:0] ST_NO_VIF     = 4'd6;
  localparam logic [3:0] ST_NO_CLEN    = 4'd7;
  localparam logic [3:0] ST_LONG_CVIF  = 4'd8;
  localparam logic [3:0] ST_TRUNC_CVIF = 4'd9;
  localparam logic [3:0] ST_TRUNC_VIFE = 4'd10;
  localparam logic [3:0] ST_MANY_VIFE  = 4'd11;
  localparam logic [3:0] ST_NO_LVAR    = 4'd12;
  localparam logic [3:0] ST_BAD_LVAR   = 4'd13;
  localparam logic [3:0] ST_TRUNC_DATA = 4'd14;

  // value kinds
  localparam logic [3:0] VK_NONE  = 4'd0;
  localparam logic [3:0] VK_INT   = 4'd1;
  localparam logic [3:0] VK_BCD   = 4'd2;
  localparam logic [3:0] VK_REAL  = 4'd3;
  localparam logic [3:0] VK_DATE  = 4'd4;
  localparam logic [3:0] VK_ASCII = 4'd5;
  localparam logic [3:0] VK_LBCD  = 4'd6;
  localparam logic [3:0] VK_NBCD  = 4'd7;
  localparam logic [3:0] VK_BIN   = 4'd8;
  localparam logic [3:0] VK_LREAL = 4'd9;

  // special bytes
  localparam logic [7:0] FILL_BYTE  = 8'h2F;
  localparam logic [7:0] DIF_MANUF  = 8'h0F;
  localparam logic [7:0] DIF_MORE   = 8'h1F;
  localparam logic [3:0] CODE_LVAR  = 4'hD;
  localparam logic [6:0] VIF_CUSTOM = 7'h7C;

  // parsed event handed from the parser to the value decoder
  typedef struct packed {
    logic        has_result;
    logic        end_flag;
    logic        is_record;
    logic [3:0]  status;
    logic [7:0]  offset;
    logic [7:0]  dif;
    logic [32:0] storage;
    logic [15:0] tariff;
    logic [7:0]  subunit;
    logic [7:0]  vif;
    logic [14:0] key;
    logic [7:0]  lvar;
    logic [7:0]  len;
    logic [63:0] value;
    logic [63:0] bcd;
  } ev_t;

  function automatic logic [63:0] pow10(input logic [3:0] e);
    logic [63:0] p;
    case (e)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

>>> rtl/mbrd_parser.sv
// ---------------------------------------------------------------------------
// mbrd_parser
// per-byte record parser: header state, accumulators, event register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrd_parser #(
  parameter int MAX_PAYLOAD    = 256,
  parameter int MAX_EXT_BYTES  = 8,
  parameter int MAX_CUSTOM_VIF = 128
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               advance,
  input  wire               take,
  input  wire  [7:0]        data_byte,
  input  wire               last_byte,
  output mbrd_pkg::ev_t     ev
);
  import mbrd_pkg::*;

  localparam int OFFSET_CAP = (MAX_PAYLOAD - 1 < 255) ? MAX_PAYLOAD - 1 : 255;

  typedef enum logic [7:0] {
    PH_DIF   = 8'b0000_0001,
    PH_DIFE  = 8'b0000_0010,
    PH_VIF   = 8'b0000_0100,
    PH_CLEN  = 8'b0000_1000,
    PH_CSKIP = 8'b0001_0000,
    PH_VIFE  = 8'b0010_0000,
    PH_LVAR  = 8'b0100_0000,
    PH_DATA  = 8'b1000_0000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  byte_offset, start_offset, start_offset_next;
  logic [7:0]  dif_hold, dif_hold_next, vif_hold, vif_hold_next;
  logic [3:0]  dife_count, dife_count_next, vife_count, vife_count_next;
  logic [32:0] storage_acc, storage_acc_next;
  logic [15:0] tariff_acc, tariff_acc_next;
  logic [7:0]  subunit_acc, subunit_acc_next;
  logic [14:0] key_hold, key_hold_next;
  logic [7:0]  bytes_left, bytes_left_next, lvar_hold, lvar_hold_next;
  logic [63:0] value_acc, value_acc_next, bcd_acc, bcd_acc_next;
  logic        halted, halted_next;
  ev_t         ev_next;

  function automatic logic [7:0] data_len(input logic [7:0] d, input logic [7:0] l);
    logic [7:0] n;
    if (d[3:0] == CODE_LVAR) begin
      if (l <= 8'hBF)      n = l;
      else if (l <= 8'hCF) n = l - 8'hC0;
      else if (l <= 8'hDF) n = l - 8'hD0;
      else if (l <= 8'hEF) n = l - 8'hE0;
      else if (l <= 8'hF4) n = {l[5:0] - 6'h2C, 2'b00};
      else if (l == 8'hF5) n = 8'd48;
      else if (l == 8'hF6) n = 8'd64;
      else                 n = 8'd0;
    end else begin
      case (d[3:0])
        4'h1, 4'h9: n = 8'd1;
        4'h2, 4'hA: n = 8'd2;
        4'h3, 4'hB: n = 8'd3;
        4'h4, 4'h5, 4'hC: n = 8'd4;
        4'h6, 4'hE: n = 8'd6;
        4'h7: n = 8'd8;
        default: n = 8'd0;
      endcase
    end
    return n;
  endfunction

  always_comb begin
    logic        go_next, go_done, do_ac, do_av, do_sd, err;
    logic [3:0]  code;
    logic [7:0]  dl, idx;
    logic [63:0] wide;
    logic [7:0]  dig;
    phase_t      np;
    go_next = 1'b0; go_done = 1'b0; do_ac = 1'b0; do_av = 1'b0; do_sd = 1'b0;
    err = 1'b0; code = ST_RECORD; dl = 8'd0; idx = 8'd0; wide = '0; dig = 8'd0;
    np = PH_DIF;
    phase_next        = phase;
    start_offset_next = start_offset;
    dif_hold_next     = dif_hold;
    vif_hold_next     = vif_hold;
    dife_count_next   = dife_count;
    vife_count_next   = vife_count;
    storage_acc_next  = storage_acc;
    tariff_acc_next   = tariff_acc;
    subunit_acc_next  = subunit_acc;
    key_hold_next     = key_hold;
    bytes_left_next   = bytes_left;
    lvar_hold_next    = lvar_hold;
    value_acc_next    = value_acc;
    bcd_acc_next      = bcd_acc;
    halted_next       = halted;
    ev_next           = '0;

    if (!halted) begin
      case (phase)
        PH_DIF: begin
          if (data_byte != FILL_BYTE) begin
            start_offset_next = byte_offset;
            dif_hold_next     = data_byte;
            vif_hold_next     = 8'd0;
            key_hold_next     = '0;
            lvar_hold_next    = 8'd0;
            value_acc_next    = '0;
            bcd_acc_next      = '0;
            dife_count_next   = 4'd0;
            vife_count_next   = 4'd0;
            bytes_left_next   = 8'd0;
            tariff_acc_next   = '0;
            subunit_acc_next  = '0;
            storage_acc_next  = {32'd0, data_byte[6]};
            if (data_byte == DIF_MANUF || data_byte == DIF_MORE) begin
              err  = 1'b1;
              code = (data_byte == DIF_MANUF) ? ST_MANUF : ST_MORE;
            end else begin
              go_next = 1'b1;
              np = data_byte[7] ? PH_DIFE : PH_VIF;
            end
          end
        end
        PH_DIFE: begin
          if (dife_count < 4'd10) begin
            wide = {60'd0, data_byte[3:0]} << (6'd1 + {dife_count, 2'b00});
            storage_acc_next = storage_acc | wide[32:0];
            wide = {62'd0, data_byte[5:4]} << {dife_count, 1'b0};
            tariff_acc_next = tariff_acc | wide[15:0];
            wide = {63'd0, data_byte[6]} << dife_count;
            subunit_acc_next = subunit_acc | wide[7:0];
          end
          dife_count_next = dife_count + 4'd1;
          if ({1'b0, dife_count} + 5'd1 > 5'(MAX_EXT_BYTES)) begin
            err = 1'b1; code = ST_MANY_DIFE;
          end else begin
            go_next = 1'b1;
            np = data_byte[7] ? PH_DIFE : PH_VIF;
          end
        end
        PH_VIF: begin
          vif_hold_next = data_byte;
          key_hold_next = {8'd0, data_byte[6:0]};
          if (data_byte[6:0] == VIF_CUSTOM) begin
            go_next = 1'b1; np = PH_CLEN;
          end else begin
            do_ac = 1'b1;
          end
        end
        PH_CLEN: begin
          if ({1'b0, data_byte} > 9'(MAX_CUSTOM_VIF)) begin
            err = 1'b1; code = ST_LONG_CVIF;
          end else if (data_byte == 8'd0) begin
            do_ac = 1'b1;
          end else begin
            bytes_left_next = data_byte;
            go_next = 1'b1; np = PH_CSKIP;
          end
        end
        PH_CSKIP: begin
          bytes_left_next = (bytes_left != 8'd0) ? bytes_left - 8'd1 : 8'd0;
          if (bytes_left_next != 8'd0) begin
            go_next = 1'b1; np = PH_CSKIP;
          end else begin
            do_ac = 1'b1;
          end
        end
        PH_VIFE: begin
          if (vife_count == 4'd0 && (vif_hold == 8'hFB || vif_hold == 8'hFC ||
              vif_hold == 8'hFD || vif_hold == 8'hEF || vif_hold == 8'hFF)) begin
            key_hold_next = {vif_hold[6:0], 1'b0, data_byte[6:0]};
          end
          vife_count_next = vife_count + 4'd1;
          if ({1'b0, vife_count} + 5'd1 > 5'(MAX_EXT_BYTES)) begin
            err = 1'b1; code = ST_MANY_VIFE;
          end else if (data_byte[7]) begin
            go_next = 1'b1; np = PH_VIFE;
          end else begin
            do_av = 1'b1;
          end
        end
        PH_LVAR: begin
          if (data_byte >= 8'hF7) begin
            err = 1'b1; code = ST_BAD_LVAR;
          end else begin
            lvar_hold_next = data_byte;
            do_sd = 1'b1;
          end
        end
        PH_DATA: begin
          idx = data_len(dif_hold, lvar_hold) - bytes_left;
          if (idx < 8'd8) begin
            wide = {56'd0, data_byte} << {idx[2:0], 3'b000};
            value_acc_next = value_acc | wide;
            dig = 8'(data_byte[7:4] * 4'd10) + {4'd0, data_byte[3:0]};
            bcd_acc_next = bcd_acc + 64'(dig * pow10({idx[2:0], 1'b0}));
          end
          bytes_left_next = bytes_left - 8'd1;
          if (bytes_left_next != 8'd0) begin
            go_next = 1'b1; np = PH_DATA;
          end else begin
            go_done = 1'b1;
          end
        end
        default: phase_next = PH_DIF;
      endcase

      // routing after the custom vif and vife sections
      if (do_ac) begin
        if (vif_hold_next[7]) begin
          go_next = 1'b1; np = PH_VIFE;
        end else begin
          do_av = 1'b1;
        end
      end
      if (do_av) begin
        if (dif_hold_next[3:0] == CODE_LVAR) begin
          go_next = 1'b1; np = PH_LVAR;
        end else begin
          do_sd = 1'b1;
        end
      end
      if (do_sd) begin
        dl = data_len(dif_hold_next, lvar_hold_next);
        value_acc_next  = '0;
        bcd_acc_next    = '0;
        bytes_left_next = dl;
        if (dl != 8'd0) begin
          go_next = 1'b1; np = PH_DATA;
        end else begin
          go_done = 1'b1;
        end
      end

      if (go_done) begin
        phase_next         = PH_DIF;
        ev_next.has_result = 1'b1;
        ev_next.is_record  = 1'b1;
        ev_next.status     = ST_RECORD;
        ev_next.offset     = start_offset_next;
        ev_next.dif        = dif_hold_next;
        ev_next.storage    = storage_acc_next;
        ev_next.tariff     = tariff_acc_next;
        ev_next.subunit    = subunit_acc_next;
        ev_next.vif        = vif_hold_next;
        ev_next.key        = key_hold_next;
        ev_next.lvar       = lvar_hold_next;
        ev_next.len        = data_len(dif_hold_next, lvar_hold_next);
        ev_next.value      = value_acc_next;
        ev_next.bcd        = bcd_acc_next;
      end else if (go_next) begin
        phase_next = np;
        if (last_byte) begin
          err = 1'b1;
          case (np)
            PH_DIFE:  code = ST_TRUNC_DIFE;
            PH_VIF:   code = ST_NO_VIF;
            PH_CLEN:  code = ST_NO_CLEN;
            PH_CSKIP: code = ST_TRUNC_CVIF;
            PH_VIFE:  code = ST_TRUNC_VIFE;
            PH_LVAR:  code = ST_NO_LVAR;
            default:  code = ST_TRUNC_DATA;
          endcase
        end
      end

      if (err) begin
        ev_next            = '0;
        ev_next.has_result = 1'b1;
        ev_next.status     = code;
        ev_next.offset     = start_offset_next;
        ev_next.dif        = dif_hold_next;
        ev_next.vif        = vif_hold_next;
        halted_next        = 1'b1;
      end
    end

    // payload end closes everything
    if (last_byte) begin
      if (!ev_next.has_result) begin
        ev_next            = '0;
        ev_next.has_result = 1'b1;
        ev_next.status     = ST_END;
      end
      ev_next.end_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_DIF;
      byte_offset  <= 8'd0;
      start_offset <= 8'd0;
      dif_hold     <= 8'd0;
      vif_hold     <= 8'd0;
      dife_count   <= 4'd0;
      vife_count   <= 4'd0;
      storage_acc  <= '0;
      tariff_acc   <= '0;
      subunit_acc  <= '0;
      key_hold     <= '0;
      bytes_left   <= 8'd0;
      lvar_hold    <= 8'd0;
      value_acc    <= '0;
      bcd_acc      <= '0;
      halted       <= 1'b0;
      ev           <= '0;
    end else if (advance) begin
      ev <= take ? ev_next : '0;
      if (take) begin
        if (last_byte) begin
          phase        <= PH_DIF;
          byte_offset  <= 8'd0;
          start_offset <= 8'd0;
          dif_hold     <= 8'd0;
          vif_hold     <= 8'd0;
          dife_count   <= 4'd0;
          vife_count   <= 4'd0;
          storage_acc  <= '0;
          tariff_acc   <= '0;
          subunit_acc  <= '0;
          key_hold     <= '0;
          bytes_left   <= 8'd0;
          lvar_hold    <= 8'd0;
          value_acc    <= '0;
          bcd_acc      <= '0;
          halted       <= 1'b0;
        end else begin
          phase        <= phase_next;
          if ({1'b0, byte_offset} < 9'(OFFSET_CAP)) begin
            byte_offset <= byte_offset + 8'd1;
          end
          start_offset <= start_offset_next;
          dif_hold     <= dif_hold_next;
          vif_hold     <= vif_hold_next;
          dife_count   <= dife_count_next;
          vife_count   <= vife_count_next;
          storage_acc  <= storage_acc_next;
          tariff_acc   <= tariff_acc_next;
          subunit_acc  <= subunit_acc_next;
          key_hold     <= key_hold_next;
          bytes_left   <= bytes_left_next;
          lvar_hold    <= lvar_hold_next;
          value_acc    <= value_acc_next;
          bcd_acc      <= bcd_acc_next;
          halted       <= halted_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mbrd_decode.sv
// ---------------------------------------------------------------------------
// mbrd_decode
// turns a parsed record into its value kind and 64-bit raw value
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbrd_decode (
  input  wire mbrd_pkg::ev_t ev,
  output logic [3:0]         value_kind,
  output logic [63:0]        value_bits
);
  import mbrd_pkg::*;

  logic [3:0]  low;
  logic [6:0]  sh;
  logic [5:0]  top_pos;
  logic [63:0] top_word;
  logic [63:0] bcd_fix;

  assign low      = ev.dif[3:0];
  assign sh       = 7'd64 - {ev.len[3:0], 3'b000};
  assign top_pos  = 6'({ev.len[3:0], 3'b000} - 7'd4);
  assign top_word = ev.value >> top_pos;
  // drop the sign nibble that was summed as fifteen
  assign bcd_fix  = ev.bcd - 64'(64'd15 * pow10(4'({ev.len[2:0], 1'b0} - 4'd1)));

  always_comb begin
    value_kind = VK_NONE;
    value_bits = '0;
    if (ev.is_record) begin
      if (low == CODE_LVAR) begin
        if (ev.lvar <= 8'hBF) begin
          value_kind = VK_ASCII;
        end else if (ev.lvar <= 8'hCF) begin
          value_kind = VK_LBCD;
          if (ev.len <= 8'd8) value_bits = ev.bcd;
        end else if (ev.lvar <= 8'hDF) begin
          value_kind = VK_NBCD;
          if (ev.len <= 8'd8) value_bits = 64'd0 - ev.bcd;
        end else if (ev.lvar <= 8'hEF) begin
          value_kind = VK_BIN;
          if (ev.len <= 8'd7) value_bits = ev.value;
        end else if (ev.lvar == 8'hF4) begin
          value_kind = VK_REAL;
          value_bits = {32'd0, ev.value[31:0]};
        end else begin
          value_kind = VK_LREAL;
        end
      end else if (ev.key == 15'h6C || ev.key == 15'h6D) begin
        value_kind = VK_DATE;
        value_bits = ev.value;
      end else begin
        case (low) inside
          4'h1, 4'h2, 4'h3, 4'h4, 4'h6, 4'h7: begin
            value_kind = VK_INT;
            value_bits = 64'($signed(ev.value << sh) >>> sh);
          end
          4'h9, 4'hA, 4'hB, 4'hC, 4'hE: begin
            value_kind = VK_BCD;
            value_bits = (top_word[3:0] == 4'hF) ? 64'd0 - bcd_fix : ev.bcd;
          end
          4'h5: begin
            value_kind = VK_REAL;
            value_bits = {32'd0, ev.value[31:0]};
          end
          default: value_kind = VK_NONE;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/meter_bus_record_deframer.sv
// ---------------------------------------------------------------------------
// meter_bus_record_deframer
// parses m-bus application payload records one byte per transaction
// ---------------------------------------------------------------------------
// Takes one payload byte per cycle on the slave stream (tlast marks the final
// byte) and returns one result transaction per complete record, special DIF
// (0x0F/0x1F), error, or payload end. On the way to the output the parser
// registers an event, the decoder turns it into the value and the result
// register holds it. The pipe advances whenever the result register is empty
// or being taken, so a new byte is accepted every cycle while the result side
// is not stalling. BCD values are summed digit pair by digit pair as the data
// bytes arrive, so no long multiply-add chain sits in one cycle.
`timescale 1ns / 1ps
`default_nettype none

module meter_bus_record_deframer #(
  parameter int MAX_PAYLOAD    = 256,
  parameter int MAX_EXT_BYTES  = 8,
  parameter int MAX_CUSTOM_VIF = 128
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // data_byte
  input  wire          s_tlast,   // last_byte
  output logic         m_tvalid,
  input  wire          m_tready,
  // status, record offset, dif, storage number, tariff number,
  // subunit number, vif raw, vif key, value kind, value bits, byte count
  output logic [175:0] m_tdata,
  output logic         m_tlast    // end_flag
);
  import mbrd_pkg::*;

  logic       advance;
  ev_t        ev;
  logic [3:0]  value_kind;
  logic [63:0] value_bits;

  // whole pipe moves when the result slot is free or being taken
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  mbrd_parser #(
    .MAX_PAYLOAD    (MAX_PAYLOAD),
    .MAX_EXT_BYTES  (MAX_EXT_BYTES),
    .MAX_CUSTOM_VIF (MAX_CUSTOM_VIF)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .take      (s_tvalid && advance),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .ev        (ev)
  );

  mbrd_decode u_decode (
    .ev         (ev),
    .value_kind (value_kind),
    .value_bits (value_bits)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= ev.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {(ev.is_record ? ev.len : 8'd0), value_bits, value_kind, ev.key,
                  ev.vif, ev.subunit, ev.tariff, ev.storage, ev.dif, ev.offset,
                  ev.status};
      m_tlast <= ev.end_flag;
    end
  end

endmodule

`default_nettype wire
